@@ src/rrc_pkg.sv @@
package rrc_pkg;

  // Field widths fixed by the stream format.
  localparam int COORD_W    = 24;
  localparam int HEADING_W  = 12;
  localparam int SIZE_W     = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 192;
  localparam int N_COORDS   = 8;

  // Defaults for the top-level parameters.
  localparam int ANGLE_BITS_DEF     = 12;
  localparam int TRIG_FRAC_BITS_DEF = 15;

  localparam logic [SIZE_W-1:0] HALF_LENGTH_RST = 16'd2560;
  localparam logic [SIZE_W-1:0] HALF_WIDTH_RST  = 16'd1280;

  // Saturation limits of a Q15.8 coordinate.
  localparam logic signed [COORD_W:0] COORD_MAX = 25'sd8388607;
  localparam logic signed [COORD_W:0] COORD_MIN = -25'sd8388608;

  // pi in Q30, used to build the sine table.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Register selected by address bit 2.
  typedef enum logic {
    REG_HALF_LENGTH = 1'b0,
    REG_HALF_WIDTH  = 1'b1
  } cfg_reg_t;

  // Unsigned 64-bit quotient by shift and subtract, for table building only.
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(pi*k/(2Q)) in Q1.frac_bits, Q = 2^(angle_bits-2), from a Q30 Taylor
  // series rounded half up. Only evaluated while building the constant table.
  function automatic logic [63:0] quarter_sine(input logic [63:0] k,
                                               input int angle_bits,
                                               input int frac_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] div;
    logic [63:0] sum_u;
    longint      sum;
    int          n;
    x   = (k * PI_Q30 + (64'd1 << (angle_bits - 2))) >> (angle_bits - 1);
    x2  = (x * x + (64'd1 << 29)) >> 30;
    t   = x;
    sum = longint'(x);
    for (n = 1; n < 20; n++) begin
      if (t != 64'd0) begin
        div = 64'((2 * n) * (2 * n + 1));
        t   = udiv64((t * x2) >> 30, div);
        if (n[0]) begin
          sum = sum - longint'(t);
        end else begin
          sum = sum + longint'(t);
        end
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    sum_u = 64'(sum);
    return (sum_u + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
  endfunction

endpackage

@@ src/rrc_sine_rom.sv @@
module rrc_sine_rom import rrc_pkg::*; #(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ANGLE_BITS-2:0]   addr_a,
  input  logic [ANGLE_BITS-2:0]   addr_b,
  output logic [TRIG_FRAC_BITS:0] data_a,
  output logic [TRIG_FRAC_BITS:0] data_b
);

  // Quarter wave, both end points included.
  localparam int DEPTH   = (1 << (ANGLE_BITS - 2)) + 1;
  localparam int ENTRY_W = TRIG_FRAC_BITS + 1;

  typedef logic [ENTRY_W-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t tbl;
    int   k;
    for (k = 0; k < DEPTH; k++) begin
      tbl[k] = ENTRY_W'(quarter_sine(64'(k), ANGLE_BITS, TRIG_FRAC_BITS));
    end
    return tbl;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= SINE_ROM[addr_a];
      data_b <= SINE_ROM[addr_b];
    end
  end

endmodule

@@ src/rotated_rect_corners.sv @@
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  centre_x, centre_y, heading
// m_*       out        m_tvalid/m_tready  four corners, x then y for each
// APB       in/out     psel/penable       half_length (0x0), half_width (0x4)
//
// One item is accepted per cycle while s_tready is high; its corners are valid once it reaches
// the output register. Stages: sine table read, four rotation products, corner
// sums with rounding, centre add with saturation into the output register.
// Each stage holds its item only while the stage after it is full and stalled,
// so empty stages still take new items while a result waits on m_tready.
// Reset (rst, synchronous) empties the pipeline and restores the default sizes.
module rotated_rect_corners import rrc_pkg::*; #(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata, from bit 0: centre_x[23:0], centre_y[47:24], heading[59:48]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // m_tdata, from bit 0: front_right_x, front_right_y, front_left_x,
  // front_left_y, rear_left_x, rear_left_y, rear_right_x, rear_right_y,
  // 24 bits each
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W   = ANGLE_BITS - 1;
  localparam int HEAD_XW = (HEADING_W > ANGLE_BITS) ? HEADING_W : ANGLE_BITS;
  localparam int TRIG_W  = TRIG_FRAC_BITS + 2;          // signed, spans +-1.0
  localparam int PROD_W  = SIZE_W + 1 + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int RND_W   = SUM_W + 1;
  localparam int D_W     = RND_W - TRIG_FRAC_BITS;
  localparam logic [IDX_W-1:0] QUARTER = IDX_W'(1) << (ANGLE_BITS - 2);
  localparam logic signed [RND_W-1:0] RND_HALF =
    RND_W'(1) <<< (TRIG_FRAC_BITS - 1);

  // ---------------------------------------------------------------------
  // Configuration registers. Address bit 2 selects the register.
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0] half_length;
  logic [SIZE_W-1:0] half_width;
  cfg_reg_t          wr_sel;
  cfg_reg_t          rd_sel;

  assign pready = 1'b1;
  assign wr_sel = cfg_reg_t'(paddr[2]);
  assign rd_sel = cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= HALF_LENGTH_RST;
      half_width  <= HALF_WIDTH_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (wr_sel)
        REG_HALF_LENGTH: half_length <= pwdata[SIZE_W-1:0];
        REG_HALF_WIDTH:  half_width  <= pwdata[SIZE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (rd_sel)
      REG_HALF_LENGTH: prdata = CFG_DATA_W'(half_length);
      REG_HALF_WIDTH:  prdata = CFG_DATA_W'(half_width);
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its item moves on.
  // ---------------------------------------------------------------------
  logic v_a, v_b, v_c, v_d;
  logic load_a, load_b, load_c, load_d;

  assign load_d   = !v_d || m_tready;
  assign load_c   = !v_c || load_d;
  assign load_b   = !v_b || load_c;
  assign load_a   = !v_a || load_b;
  assign s_tready = load_a;
  assign m_tvalid = v_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      if (load_a) begin
        v_a <= s_tvalid;
      end
      if (load_b) begin
        v_b <= v_a;
      end
      if (load_c) begin
        v_c <= v_b;
      end
      if (load_d) begin
        v_d <= v_c;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: split the heading into quadrant and offset, and read the
  // sine of the offset and of its complement from the quarter-wave table.
  // ---------------------------------------------------------------------
  logic [HEAD_XW-1:0]    head_x;
  logic [ANGLE_BITS-1:0] head;
  logic [IDX_W-1:0]      addr_lo;
  logic [IDX_W-1:0]      addr_hi;
  logic [TRIG_FRAC_BITS:0] lo_a;
  logic [TRIG_FRAC_BITS:0] hi_a;
  logic signed [COORD_W-1:0] cx_a, cy_a;
  logic [1:0]                quad_a;

  assign head_x  = HEAD_XW'(s_tdata[2*COORD_W +: HEADING_W]);
  assign head    = head_x[ANGLE_BITS-1:0];
  assign addr_lo = {1'b0, head[ANGLE_BITS-3:0]};
  assign addr_hi = QUARTER - addr_lo;

  rrc_sine_rom #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_sine_rom (
    .clk    (clk),
    .en     (load_a),
    .addr_a (addr_lo),
    .addr_b (addr_hi),
    .data_a (lo_a),
    .data_b (hi_a)
  );

  always_ff @(posedge clk) begin
    if (load_a) begin
      cx_a   <= signed'(s_tdata[0 +: COORD_W]);
      cy_a   <= signed'(s_tdata[COORD_W +: COORD_W]);
      quad_a <= head[ANGLE_BITS-1 -: 2];
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: fold the quadrant into signed sine and cosine, then form the
  // four products of the half sizes with them.
  // ---------------------------------------------------------------------
  logic signed [TRIG_W-1:0] lo_s, hi_s, sin_b, cos_b;
  logic signed [SIZE_W:0]   len_s, wid_s;
  logic signed [PROD_W-1:0] p_lc, p_ls, p_ws, p_wc;
  logic signed [COORD_W-1:0] cx_b, cy_b;

  assign lo_s  = signed'({1'b0, lo_a});
  assign hi_s  = signed'({1'b0, hi_a});
  assign len_s = signed'({1'b0, half_length});
  assign wid_s = signed'({1'b0, half_width});

  always_comb begin
    unique case (quad_a)
      2'd0: begin
        sin_b = lo_s;
        cos_b = hi_s;
      end
      2'd1: begin
        sin_b = hi_s;
        cos_b = -lo_s;
      end
      2'd2: begin
        sin_b = -lo_s;
        cos_b = -hi_s;
      end
      default: begin
        sin_b = -hi_s;
        cos_b = lo_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      p_lc <= len_s * cos_b;
      p_ls <= len_s * sin_b;
      p_ws <= wid_s * sin_b;
      p_wc <= wid_s * cos_b;
      cx_b <= cx_a;
      cy_b <= cy_a;
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: combine products into the eight rotated offsets and round each
  // half up to Q.8 (the arithmetic shift floors).
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] e_lc, e_ls, e_ws, e_wc;
  logic signed [SUM_W-1:0] sum_c [N_COORDS];
  logic signed [RND_W-1:0] rnd_c [N_COORDS];
  logic signed [D_W-1:0]   d_c   [N_COORDS];
  logic signed [COORD_W-1:0] cx_c, cy_c;

  assign e_lc = SUM_W'(p_lc);
  assign e_ls = SUM_W'(p_ls);
  assign e_ws = SUM_W'(p_ws);
  assign e_wc = SUM_W'(p_wc);

  // Corner offsets (a, b): x = a*cos - b*sin, y = a*sin + b*cos.
  assign sum_c[0] =  e_lc + e_ws;   // front right x
  assign sum_c[1] =  e_ls - e_wc;   // front right y
  assign sum_c[2] =  e_lc - e_ws;   // front left x
  assign sum_c[3] =  e_ls + e_wc;   // front left y
  assign sum_c[4] = -e_lc - e_ws;   // rear left x
  assign sum_c[5] = -e_ls + e_wc;   // rear left y
  assign sum_c[6] = -e_lc + e_ws;   // rear right x
  assign sum_c[7] = -e_ls - e_wc;   // rear right y

  always_comb begin
    for (int k = 0; k < N_COORDS; k++) begin
      rnd_c[k] = RND_W'(sum_c[k]) + RND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (load_c) begin
      for (int k = 0; k < N_COORDS; k++) begin
        d_c[k] <= D_W'(rnd_c[k] >>> TRIG_FRAC_BITS);
      end
      cx_c <= cx_b;
      cy_c <= cy_b;
    end
  end

  // ---------------------------------------------------------------------
  // Stage D: add the centre and saturate into the output register.
  // ---------------------------------------------------------------------
  logic signed [COORD_W:0]   pos_d [N_COORDS];
  logic signed [COORD_W-1:0] sat_d [N_COORDS];
  logic signed [COORD_W-1:0] coord_q [N_COORDS];

  always_comb begin
    for (int k = 0; k < N_COORDS; k++) begin
      pos_d[k] = (k[0] ? (COORD_W + 1)'(cy_c) : (COORD_W + 1)'(cx_c)) +
                 (COORD_W + 1)'(d_c[k]);
      if (pos_d[k] > COORD_MAX) begin
        sat_d[k] = COORD_W'(COORD_MAX);
      end else if (pos_d[k] < COORD_MIN) begin
        sat_d[k] = COORD_W'(COORD_MIN);
      end else begin
        sat_d[k] = pos_d[k][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_d) begin
      for (int k = 0; k < N_COORDS; k++) begin
        coord_q[k] <= sat_d[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < N_COORDS; k++) begin
      m_tdata[k*COORD_W +: COORD_W] = coord_q[k];
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid straight after reset");

  a_stage_c_to_out: assert property (@(posedge clk) disable iff (rst)
    (v_c && load_d) |=> m_tvalid)
    else $error("item lost between rounding stage and output");

  a_cos_nonzero: assert property (@(posedge clk) disable iff (rst)
    v_a |-> (hi_a != '0))
    else $error("complementary sine read as zero");

  a_zero_size: assert property (@(posedge clk) disable iff (rst)
    (v_a && load_b && half_length == '0 && half_width == '0) |=>
    (p_lc == '0 && p_ls == '0 && p_ws == '0 && p_wc == '0))
    else $error("zero-sized rectangle gave non-zero offsets");

endmodule

@@ tb/rrc_corner_checker.sv @@
`timescale 1ns / 100ps

module rrc_corner_checker import rrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    mismatches,
  output int                    corners_pending,
  output int                    corners_seen
);

  localparam int ANG      = ANGLE_BITS_DEF;
  localparam int FRAC     = TRIG_FRAC_BITS_DEF;
  localparam int QTR      = 1 << (ANG - 2);
  localparam int HALF_ULP = 1 << (FRAC - 1);

  // Local copy of the size registers, kept in step with the APB writes.
  logic [SIZE_W-1:0] half_len;
  logic [SIZE_W-1:0] half_wid;

  longint sine_rom [0:QTR];
  logic [OUT_DATA_W-1:0] corners_due [$];
  int fail_total = 0;
  int seen_total = 0;

  initial begin
    for (int k = 0; k <= QTR; k++) begin
      sine_rom[k] = sine_entry(k);
    end
  end

  // Quarter-wave sine in Q1.FRAC: Taylor series in Q30, rounded half up.
  function automatic longint sine_entry(input longint k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (64'(k) * PI_Q30 + (64'd1 << (ANG - 2))) >> (ANG - 1);
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n < 20; n++) begin
      if (term != 64'd0) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    return longint'((64'(sum) + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
  endfunction

  // Rounds the rotated offset half up to Q.8, adds the centre and saturates.
  function automatic longint place_coord(input longint centre, input longint a,
                                         input longint ta, input longint b,
                                         input longint tb);
    longint acc;
    longint v;
    acc = a * ta + b * tb;
    v   = centre + ((acc + HALF_ULP) >>> FRAC);
    if (v > longint'(COORD_MAX)) begin
      v = longint'(COORD_MAX);
    end
    if (v < longint'(COORD_MIN)) begin
      v = longint'(COORD_MIN);
    end
    return v;
  endfunction

  function automatic logic [OUT_DATA_W-1:0] predict_corners(input logic [IN_DATA_W-1:0] pose);
    logic [OUT_DATA_W-1:0] corners;
    logic [ANG-1:0]        angle;
    longint cx, cy, lo, hi, sn, cs, a, b, x, y;
    int     quad, r;
    cx    = longint'($signed(pose[COORD_W-1:0]));
    cy    = longint'($signed(pose[2*COORD_W-1:COORD_W]));
    angle = pose[2*COORD_W +: ANG];
    quad  = int'(angle >> (ANG - 2));
    r     = int'(angle) & (QTR - 1);
    lo    = sine_rom[r];
    hi    = sine_rom[QTR - r];
    case (quad)
      0: begin
        sn = lo;
        cs = hi;
      end
      1: begin
        sn = hi;
        cs = -lo;
      end
      2: begin
        sn = -lo;
        cs = -hi;
      end
      default: begin
        sn = -hi;
        cs = lo;
      end
    endcase
    // Corners in order front-right, front-left, rear-left, rear-right.
    for (int k = 0; k < 4; k++) begin
      a = (k < 2) ? longint'(half_len) : -longint'(half_len);
      b = (k == 1 || k == 2) ? longint'(half_wid) : -longint'(half_wid);
      x = place_coord(cx, a, cs, b, -sn);
      y = place_coord(cy, a, sn, b, cs);
      corners[(2*k)*COORD_W +: COORD_W]   = x[COORD_W-1:0];
      corners[(2*k+1)*COORD_W +: COORD_W] = y[COORD_W-1:0];
    end
    return corners;
  endfunction

  function automatic string corner_label(input int i);
    case (i)
      0: return "front_right_x";
      1: return "front_right_y";
      2: return "front_left_x";
      3: return "front_left_y";
      4: return "rear_left_x";
      5: return "rear_left_y";
      6: return "rear_right_x";
      default: return "rear_right_y";
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    fail_total++;
    if (fail_total <= 40) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin : watch
    logic [OUT_DATA_W-1:0] due;
    logic [SIZE_W-1:0]     held;
    if (rst) begin
      half_len = HALF_LENGTH_RST;
      half_wid = HALF_WIDTH_RST;
      corners_due.delete();
    end else begin
      if (psel && penable && pready && pwrite) begin
        if (cfg_reg_t'(paddr[2]) == REG_HALF_LENGTH) begin
          half_len = pwdata[SIZE_W-1:0];
        end else begin
          half_wid = pwdata[SIZE_W-1:0];
        end
      end
      if (psel && penable && pready && !pwrite) begin
        held = (cfg_reg_t'(paddr[2]) == REG_HALF_LENGTH) ? half_len : half_wid;
        if (prdata[SIZE_W-1:0] !== held) begin
          report_mismatch($sformatf("read of 0x%0h gave %0d, expected %0d",
                                    paddr, prdata[SIZE_W-1:0], held));
        end
      end
      if (s_tvalid && s_tready) begin
        corners_due.push_back(predict_corners(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        seen_total++;
        if (corners_due.size() == 0) begin
          report_mismatch("corner set arrived with no pose outstanding");
        end else begin
          due = corners_due.pop_front();
          for (int i = 0; i < N_COORDS; i++) begin
            if (m_tdata[i*COORD_W +: COORD_W] !== due[i*COORD_W +: COORD_W]) begin
              report_mismatch($sformatf("result %0d %s got %0d expected %0d", seen_total,
                              corner_label(i), $signed(m_tdata[i*COORD_W +: COORD_W]),
                              $signed(due[i*COORD_W +: COORD_W])));
            end
          end
        end
      end
    end
    mismatches      <= fail_total;
    corners_pending <= corners_due.size();
    corners_seen    <= seen_total;
  end

endmodule

@@ tb/tb_rotated_rect_corners.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the oriented rectangle corner block. The checker
// beside the block watches every channel, predicts the four corners of each
// accepted pose and compares them; this module drives the block and gives the verdict.
module tb_rotated_rect_corners;
  import rrc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AT      = 300;
  localparam int PHASE_POSES  = 125;
  localparam int RANDOM_PHASES = 6;

  localparam logic [COORD_W-1:0] C_MAX = 24'h7FFFFF;
  localparam logic [COORD_W-1:0] C_MIN = 24'h800000;
  localparam logic [CFG_ADDR_W-1:0] LEN_ADDR = {REG_HALF_LENGTH, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] WID_ADDR = {REG_HALF_WIDTH, 2'b00};

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // centre_x, centre_y, heading, zero pad
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // fr_x, fr_y, fl_x, fl_y, rl_x, rl_y, rr_x, rr_y
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int corners_pending;
  int corners_seen;

  int  poses_sent;
  int  settings_used;
  int  cycles = 0;
  bit  quiet;      // set for the closing phase: neither side idles
  bit  src_gappy;  // whether the sender currently inserts gaps
  bit  hold_done;

  rotated_rect_corners u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  rrc_corner_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .mismatches      (mismatches),
    .corners_pending (corners_pending),
    .corners_seen    (corners_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The cycle counter is the only guard against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d corner sets outstanding.",
               cycles, corners_pending);
      $display("[rotated_rect_corners] ERROR");
      $finish;
    end
  end

  // Offers one pose and waits for it to be taken. The valid line is left high
  // so that back-to-back items need no second assignment in the same step.
  task automatic offer_pose(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                            input logic [HEADING_W-1:0] hd);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - 2*COORD_W - HEADING_W){1'b0}}, hd, cy, cx};
    do @(posedge clk); while (!s_tready);
    poses_sent++;
    // Every so often the sender pauses for a burst, unless the run is in its
    // closing stretch or in a run of back-to-back items.
    if (!quiet && src_gappy && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // One APB transfer: a setup phase, then the access phase until pready, then an idle
  // phase with psel low, so that the next transfer starts on a later edge.
  task automatic apb_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering and waits for every outstanding corner set, then waits out
  // the settle count so that nothing is left in flight in the pipeline.
  task automatic wait_idle(input int settle);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (corners_pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  // The sizes change only while the block is empty. Upper data bits are
  // random, since the registers hold only the low sixteen bits.
  task automatic set_sizes(input logic [SIZE_W-1:0] len, input logic [SIZE_W-1:0] wid);
    wait_idle(8);
    apb_access(1'b1, LEN_ADDR, {16'($urandom), len});
    apb_access(1'b1, WID_ADDR, {16'($urandom), wid});
    apb_access(1'b0, LEN_ADDR, '0);
    apb_access(1'b0, WID_ADDR, '0);
    settings_used++;
  endtask

  // Coordinates lean towards the ends of the range so that saturation is hit
  // often, some near zero, and the rest spread over the whole field.
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return C_MAX - COORD_W'($urandom_range(0, 3000));
      1: return C_MIN + COORD_W'($urandom_range(0, 3000));
      2: return COORD_W'($urandom_range(0, 2000) - 1000);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 3))
      0: return SIZE_W'($urandom_range(0, 255));
      1: return SIZE_W'($urandom_range(65280, 65535));
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  // Receiver: random ready bursts, one long hold-off once the run is well
  // under way so that the pipeline fills and the input side stalls, and a
  // steady ready in the closing phase.
  initial begin
    m_tready = 1'b0;
    hold_done = 1'b0;
    @(negedge rst);
    forever begin
      if (!hold_done && !quiet && poses_sent >= HOLD_AT) begin
        m_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [SIZE_W-1:0] len;
    logic [SIZE_W-1:0] wid;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    poses_sent = 0;
    settings_used = 0;
    quiet      = 1'b0;
    src_gappy  = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The reset sizes must read back before anything is written.
    apb_access(1'b0, LEN_ADDR, '0);
    apb_access(1'b0, WID_ADDR, '0);

    // Default sizes: the centre at the origin around the full turn, including
    // each quadrant boundary and the last step before wrap, then the corners
    // of the coordinate range where the offsets push a coordinate out.
    offer_pose(24'd0, 24'd0, 12'd0);
    offer_pose(24'd0, 24'd0, 12'd1);
    offer_pose(24'd0, 24'd0, 12'd511);
    offer_pose(24'd0, 24'd0, 12'd512);
    offer_pose(24'd0, 24'd0, 12'd1023);
    offer_pose(24'd0, 24'd0, 12'd1024);
    offer_pose(24'd0, 24'd0, 12'd2048);
    offer_pose(24'd0, 24'd0, 12'd3072);
    offer_pose(24'd0, 24'd0, 12'd4095);
    offer_pose(C_MAX, C_MAX, 12'd0);
    offer_pose(C_MIN, C_MIN, 12'd2048);
    offer_pose(C_MAX, C_MIN, 12'd1024);
    offer_pose(C_MIN, C_MAX, 12'd3072);

    // Largest sizes: saturation on both sides of both axes.
    set_sizes(16'hFFFF, 16'hFFFF);
    offer_pose(24'd0, 24'd0, 12'd512);
    offer_pose(C_MAX, C_MAX, 12'd0);
    offer_pose(C_MIN, C_MIN, 12'd0);
    offer_pose(C_MAX, C_MIN, 12'd1536);
    offer_pose(C_MIN, C_MAX, 12'd2560);
    offer_pose(24'd0, 24'd0, 12'd3584);

    // Zero sizes: every corner is the centre itself.
    set_sizes(16'd0, 16'd0);
    offer_pose(C_MAX, C_MIN, 12'd777);
    offer_pose(C_MIN, C_MAX, 12'd3000);
    offer_pose(24'd0, 24'd0, 12'd0);

    // Random poses under a series of size settings. The closing phase goes
    // back to the reset sizes with both sides running flat out.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1: begin
          len = 16'hFFFF;
          wid = 16'd0;
        end
        2: begin
          len = 16'd0;
          wid = 16'hFFFF;
        end
        RANDOM_PHASES - 1: begin
          len = HALF_LENGTH_RST;
          wid = HALF_WIDTH_RST;
        end
        default: begin
          len = pick_size();
          wid = pick_size();
        end
      endcase
      set_sizes(len, wid);
      quiet = (p == RANDOM_PHASES - 1);
      for (int i = 0; i < PHASE_POSES; i++) begin
        if (i % 32 == 0) begin
          src_gappy = ($urandom_range(0, 2) != 0);
        end
        offer_pose(pick_coord(), pick_coord(), HEADING_W'($urandom));
      end
    end

    wait_idle(20);
    $display("Checked %0d corner sets from %0d poses under %0d size settings,",
             corners_seen, poses_sent, settings_used + 1);
    $display("with random idling on both sides and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("[rotated_rect_corners] OK");
    end else begin
      $display("[rotated_rect_corners] ERROR");
    end
    $finish;
  end

endmodule
